/* design/linear_probe_hash_table_core_macros.svh */
// Assertion macros used by the hash table sequencer.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lpht_pkg.sv */
// Shared constants, types and command/status structures of the hash table.
`default_nettype none

package lpht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
  localparam int REQ_BITS    = 3;
  localparam int STATUS_BITS = 2;

  localparam int IN_FIELD_BITS   = REQ_BITS + KEY_BITS + VALUE_BITS;
  localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = STATUS_BITS + VALUE_BITS + CNT_BITS;
  localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [REQ_BITS-1:0] REQ_PUT    = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_GET    = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_PEEK   = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_TAKE   = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                  vld;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic issue;
    logic commit;
    logic miss;
    logic full;
  } lpht_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic put_full;
    logic no_probe;
    logic rd_vld;
    logic hit;
    logic exhausted;
  } lpht_sts_t;

endpackage

`default_nettype wire

/* design/lpht_datapath.sv */
// Slot memory, probe pointer, entry count and result registers.
`default_nettype none

module lpht_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [lpht_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  output logic      [lpht_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  input  wire lpht_pkg::lpht_cmd_t                cmd,
  output lpht_pkg::lpht_sts_t                     sts
);
  import lpht_pkg::*;

  slot_t mem [TABLE_DEPTH];

  logic [REQ_BITS-1:0]    req_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [VALUE_BITS-1:0]  value_r;
  logic [ADDR_BITS-1:0]   ptr_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic [ADDR_BITS-1:0]   rd_addr_r;
  slot_t                  rd_data_r;
  logic                   rd_vld_r;
  logic [ADDR_BITS-1:0]   clr_ptr_r;
  logic [CNT_BITS-1:0]    count_r;
  logic [STATUS_BITS-1:0] status_r;
  logic [VALUE_BITS-1:0]  vout_r;

  logic [REQ_BITS-1:0]    in_req;
  logic [KEY_BITS-1:0]    in_key;
  logic [VALUE_BITS-1:0]  in_value;
  logic is_put, is_get, is_remove, is_peek, is_take, bad_req, key_eq;
  logic                   we;
  logic [ADDR_BITS-1:0]   waddr;
  slot_t                  wdata;

  assign in_req   = in_tdata[REQ_BITS-1:0];
  assign in_key   = in_tdata[REQ_BITS +: KEY_BITS];
  assign in_value = in_tdata[REQ_BITS + KEY_BITS +: VALUE_BITS];

  assign is_put    = (req_r == REQ_PUT);
  assign is_get    = (req_r == REQ_GET);
  assign is_remove = (req_r == REQ_REMOVE);
  assign is_peek   = (req_r == REQ_PEEK);
  assign is_take   = (req_r == REQ_TAKE);
  assign bad_req   = !(is_put || is_get || is_remove || is_peek || is_take);
  assign key_eq    = (rd_data_r.key == key_r);

  // Put stops at an empty slot or its own key; lookups need a live match;
  // the any-entry scans stop at the first live slot.
  assign sts.hit = is_put                 ? (!rd_data_r.vld || key_eq) :
                   (is_get || is_remove)  ? (rd_data_r.vld && key_eq)  :
                                            rd_data_r.vld;

  assign sts.clr_done  = (clr_ptr_r == ADDR_BITS'(TABLE_DEPTH - 1));
  assign sts.put_full  = is_put && (count_r == CNT_BITS'(TABLE_DEPTH));
  assign sts.no_probe  = bad_req || (!is_put && (count_r == '0));
  assign sts.rd_vld    = rd_vld_r;
  assign sts.exhausted = (cnt_r == CNT_BITS'(TABLE_DEPTH));

  always_comb begin
    we    = cmd.clr_step || (cmd.commit && (is_put || is_remove || is_take));
    waddr = cmd.clr_step ? clr_ptr_r : rd_addr_r;
    wdata = '0;
    if (!cmd.clr_step && is_put) begin
      wdata.vld   = 1'b1;
      wdata.key   = key_r;
      wdata.value = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.issue) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req;
      key_r   <= in_key;
      value_r <= in_value;
      // The depth is a power of two, so the home slot is the low key bits.
      ptr_r   <= (in_req == REQ_PEEK || in_req == REQ_TAKE) ? '0
                                                             : in_key[ADDR_BITS-1:0];
    end else if (cmd.issue) begin
      ptr_r <= (ptr_r == ADDR_BITS'(TABLE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    end
    if (cmd.issue) begin
      rd_addr_r <= ptr_r;
    end
    if (cmd.commit) begin
      status_r <= ST_OK;
      vout_r   <= (is_get || is_peek || is_take) ? rd_data_r.value : '0;
    end else if (cmd.full) begin
      status_r <= ST_FULL;
      vout_r   <= '0;
    end else if (cmd.miss) begin
      status_r <= ST_MISSING;
      vout_r   <= '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      clr_ptr_r <= '0;
      count_r   <= '0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.clr_step && !sts.clr_done) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      if (cmd.commit) begin
        if (is_put && !rd_data_r.vld) begin
          count_r <= count_r + 1'b1;
        end else if (is_remove || is_take) begin
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  assign out_tdata = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}}, count_r, vout_r, status_r};

endmodule

`default_nettype wire

/* design/lpht_ctrl.sv */
// Request sequencer: clearing pass, request check, probe loop and result hand-off.
`default_nettype none

`include "linear_probe_hash_table_core_macros.svh"

module lpht_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output lpht_pkg::lpht_cmd_t       cmd,
  input  wire lpht_pkg::lpht_sts_t  sts
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_PROBE,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   out_tvalid_r;
  logic   hit_now;

  assign hit_now = sts.rd_vld && sts.hit;

  always_comb begin
    cmd          = '0;
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.load     = in_tvalid && in_tready_r;
    state_nxt    = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.full = sts.put_full;
        cmd.miss = !sts.put_full && sts.no_probe;
        state_nxt = (sts.put_full || sts.no_probe) ? S_RESULT : S_PROBE;
      end
      S_PROBE: begin
        cmd.commit = hit_now;
        cmd.miss   = sts.rd_vld && !sts.hit && sts.exhausted;
        cmd.issue  = !sts.exhausted && !hit_now;
        if (cmd.commit || cmd.miss) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= (state_nxt == S_IDLE);
      out_tvalid_r <= (state_nxt == S_RESULT);
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  `LPHT_ASSERT_NOW(a_one_side, in_tready_r, !out_tvalid_r, "ready while a result is pending")
  `LPHT_ASSERT_NEXT(a_commit_result, cmd.commit, out_tvalid_r, "commit without a result beat")
  `LPHT_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready_r, !in_tready_r, "ready after accept")
  `LPHT_ASSERT_NEXT(a_result_free, out_tvalid_r && out_tready, in_tready_r, "not ready after result")

endmodule

`default_nettype wire

/* design/linear_probe_hash_table_core.sv */
// Top level of the linear-probing hash table: sequencer plus slot datapath.
`default_nettype none

// Sequence: accept, a check state that may answer at once, then a probe loop from the start slot;
// a hit, or a miss once every slot has been read, leads to the result beat.
// Throughput: one request at a time; a get or remove that misses in a non-empty table
// walks all 1024 slots before its result beat.
// Reset: synchronous, active low; afterwards a clearing pass invalidates every slot while
// in_tready stays low.

module linear_probe_hash_table_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // in_tdata, lowest bit first: req_type[2:0], key[34:3], value[66:35], zero fill.
  input  wire logic [lpht_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_tdata, lowest bit first: status[1:0], value_out[33:2], entry_count[44:34], zero fill.
  output logic      [lpht_pkg::OUT_TDATA_BITS-1:0] out_tdata
);
  import lpht_pkg::*;

  // Commands from the sequencer and the status it steers by.
  lpht_cmd_t cmd;
  lpht_sts_t sts;

  // The sequencer owns the handshakes. It clears the table after reset, takes one request
  // beat in its idle state, and holds the result beat until the sink takes it.
  lpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the slot memory with its registered read port, the probe pointer,
  // the entry count and the result registers that drive out_tdata.
  lpht_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
